FILE: rtl/lcdns_pkg.sv
// Package for the LCD nibble serializer.
// Holds operation codes, control-line constants and the transfer record type.
// No dependencies.
package lcdns_pkg;

	localparam logic [1:0] OP_WRITE_CHAR = 2'd0;
	localparam logic [1:0] OP_RAW_CMD    = 2'd1;
	localparam logic [1:0] OP_SET_CURSOR = 2'd2;

	localparam logic [6:0] ADDR_ROW0_END   = 7'h10;
	localparam logic [6:0] ADDR_ROW1_START = 7'h40;
	localparam logic [6:0] ADDR_ROW1_LAST  = 7'h4F;
	localparam logic [7:0] CMD_ROW1        = 8'hC0;
	localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
	localparam logic [4:0] COLUMN_LIMIT    = 5'd16;
	localparam logic [1:0] ROW_LIMIT       = 2'd2;

	localparam logic [3:0] CTL_DATA_EN_ON  = 4'hD;
	localparam logic [3:0] CTL_DATA_EN_OFF = 4'h9;
	localparam logic [3:0] CTL_CMD_EN_ON   = 4'hC;
	localparam logic [3:0] CTL_CMD_EN_OFF  = 4'h8;

	localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd39;
	localparam int         QUEUE_DEPTH_DEFAULT  = 4;

	typedef struct packed {
		logic       pre;
		logic       rs;
		logic [7:0] value;
	} xfer_t;

endpackage

FILE: rtl/lcdns_front.sv
// Front end: accepts requests, tracks the display address counter and
// classifies each request into a transfer record. Depends on lcdns_pkg.
module lcdns_front
	import lcdns_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [1:0] operation,
	input  logic [7:0] data_byte,
	input  logic [1:0] row,
	input  logic [4:0] column,
	input  logic       q_full,
	output logic       q_push,
	output xfer_t      q_data
);

	logic [6:0] addr_q;
	logic [6:0] addr_d;
	logic [6:0] addr_wrap;
	logic [6:0] addr_cur;
	logic       emit;
	logic       accept;

	assign accept    = push && !q_full;
	assign addr_wrap = ADDR_ROW1_START;

	always_comb begin
		addr_d        = addr_q;
		addr_cur      = addr_q;
		emit          = 1'b0;
		q_data.pre    = 1'b0;
		q_data.rs     = 1'b0;
		q_data.value  = data_byte;
		case (operation)
			OP_WRITE_CHAR: begin
				if (addr_q == ADDR_ROW0_END) begin
					addr_cur   = addr_wrap;
					q_data.pre = 1'b1;
				end
				q_data.rs = 1'b1;
				if (addr_cur <= ADDR_ROW1_LAST) begin
					emit   = 1'b1;
					addr_d = addr_cur + 7'd1;
				end
			end
			OP_RAW_CMD: begin
				emit = 1'b1;
			end
			OP_SET_CURSOR: begin
				if (row < ROW_LIMIT && column < COLUMN_LIMIT) begin
					emit         = 1'b1;
					addr_d       = {row[0], 2'b00, column[3:0]};
					q_data.value = CMD_SET_DDRAM | {1'b0, addr_d};
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign q_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (accept) begin
			addr_q <= addr_d;
		end
	end

endmodule

FILE: rtl/lcdns_queue.sv
// Short transfer queue between front and back ends.
// Depends on lcdns_pkg for the record type.
module lcdns_queue
	import lcdns_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  xfer_t wdata,
	output logic  full,
	input  logic  pop,
	output xfer_t rdata,
	output logic  valid
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	xfer_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == FULL_CNT);
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/lcdns_back.sv
// Back end: expands each transfer record into expander bytes, one per cycle
// while pop keeps up, into an output register. Depends on lcdns_pkg.
module lcdns_back
	import lcdns_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  xfer_t      q_data,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] expander_byte,
	output logic       end_of_transfer,
	output logic       last
);

	logic [2:0] phase_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       eot_q;
	logic       last_q;
	logic       advance;
	logic       in_prefix;
	logic [7:0] value;
	logic       rs;
	logic       en;
	logic [3:0] nib;
	logic [3:0] ctl;
	logic       eot;
	logic       done;

	assign advance   = q_valid && (!out_valid_q || pop);
	assign in_prefix = q_data.pre && !phase_q[2];
	assign value     = in_prefix ? CMD_ROW1 : q_data.value;
	assign rs        = in_prefix ? 1'b0 : q_data.rs;
	assign en        = !phase_q[0];
	assign nib       = phase_q[1] ? value[3:0] : value[7:4];
	assign eot       = (phase_q[1:0] == 2'b11);
	assign done      = eot && (!q_data.pre || phase_q[2]);
	assign q_pop     = advance && done;

	always_comb begin
		case ({rs, en})
			2'b11:   ctl = CTL_DATA_EN_ON;
			2'b10:   ctl = CTL_DATA_EN_OFF;
			2'b01:   ctl = CTL_CMD_EN_ON;
			default: ctl = CTL_CMD_EN_OFF;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= {nib, ctl};
			eot_q  <= eot;
			last_q <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				phase_q     <= done ? 3'd0 : phase_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty           = !out_valid_q;
	assign expander_byte   = byte_q;
	assign end_of_transfer = eot_q;
	assign last            = last_q;

endmodule

FILE: rtl/lcd_nibble_serializer_top.sv
// Top level of the LCD nibble serializer: front end, transfer queue, back end
// and the device address register. Depends on lcdns_pkg and all lcdns_ modules.
//
// Takes character, raw command and set-cursor requests and emits the 4-bit-mode
// expander byte stream for a 16x2 character LCD, one byte per clock while pop
// keeps up. A character or command yields 4 bytes; a character that wraps from
// row 0 to row 1 yields 8. Dropped characters and ignored cursor moves yield
// nothing. Requests are taken one per cycle until the QUEUE_DEPTH-entry transfer
// queue fills, so the sustained rate is set by the back end at one output byte
// per cycle while pop is held. device_address may only be written while idle.
module lcd_nibble_serializer_top
	import lcdns_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] operation,
	input  logic [7:0] data_byte,
	input  logic [1:0] row,
	input  logic [4:0] column,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] expander_byte,
	output logic [7:0] bus_write_address,
	output logic       end_of_transfer,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] cfg_data
);

	logic [6:0] dev_addr_q;
	logic       q_push;
	xfer_t      q_wdata;
	logic       q_full;
	logic       q_pop;
	xfer_t      q_rdata;
	logic       q_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEVICE_ADDRESS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dev_addr_q <= cfg_data;
		end
	end

	assign bus_write_address = {dev_addr_q, 1'b0};
	assign full              = q_full;

	lcdns_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.operation (operation),
		.data_byte (data_byte),
		.row       (row),
		.column    (column),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	lcdns_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.valid  (q_valid)
	);

	lcdns_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_data          (q_rdata),
		.q_pop           (q_pop),
		.empty           (empty),
		.pop             (pop),
		.expander_byte   (expander_byte),
		.end_of_transfer (end_of_transfer),
		.last            (last)
	);

endmodule

FILE: rtl/lcdns_checker.sv
// Port-level checker for the LCD nibble serializer, bound to the top level.
// Depends only on the top level's ports.
module lcdns_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] expander_byte,
	input logic [7:0] bus_write_address,
	input logic       end_of_transfer,
	input logic       last
);

	a_last_ends_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> end_of_transfer)
		else $error("last without end_of_transfer");

	a_eot_enable_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && end_of_transfer) |-> !expander_byte[2])
		else $error("transaction ends with enable set");

	a_enable_pulse_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && expander_byte[2]) |=>
		(!empty && !expander_byte[2] &&
		 expander_byte[7:4] == $past(expander_byte[7:4])))
		else $error("enable-high byte not followed by matching enable-low byte");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(expander_byte) && $stable(last)))
		else $error("waiting transaction changed");

	a_write_direction: assert property (@(posedge clk) disable iff (!arst_n)
		!bus_write_address[0])
		else $error("bus address not in write direction");

endmodule

bind lcd_nibble_serializer_top lcdns_checker u_lcdns_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.empty             (empty),
	.pop               (pop),
	.expander_byte     (expander_byte),
	.bus_write_address (bus_write_address),
	.end_of_transfer   (end_of_transfer),
	.last              (last)
);

FILE: bench/tb_lcd_nibble_serializer_top.sv
// Self-checking bench for lcd_nibble_serializer_top: directed table, then random
// cursor/character runs under several device addresses, with bursty push and stalled pop.
// Depends on lcdns_pkg and the RTL of lcd_nibble_serializer_top.
module tb_lcd_nibble_serializer_top
	import lcdns_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 8 * QUEUE_DEPTH_DEFAULT + 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int DIRECTED_ROWS = 22;

	typedef enum logic [1:0] {FROM_MODEL, NO_OUTPUT, LCD_BYTE} row_check_e;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
		logic [1:0] r;
		logic [4:0] c;
		row_check_e chk;
		logic [7:0] value;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] xbyte;
		logic [7:0] bus_addr;
		logic       eot;
		logic       fin;
	} lcd_out_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [1:0] operation;
	logic [7:0] data_byte;
	logic [1:0] row;
	logic [4:0] column;
	logic       empty;
	logic       pop;
	logic [7:0] expander_byte;
	logic [7:0] bus_write_address;
	logic       end_of_transfer;
	logic       last;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [6:0] cfg_data;

	row_check_e row_check;
	logic [7:0] row_value;

	lcd_out_t   expected_bytes[$];
	logic [6:0] cursor_model;
	logic [6:0] dev_addr_model;
	stim_row_t  directed_rows [DIRECTED_ROWS];

	int errors = 0;
	int items_accepted = 0;
	int bytes_checked = 0;
	int row_wraps = 0;
	int dropped_chars = 0;
	int address_writes = 0;
	int burst_left;
	int idle_cycles = 0;
	int base_size;
	lcd_out_t want;
	logic [7:0] pop_pattern = 8'hFF;
	int pat_pos = 0;

	lcd_nibble_serializer_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.operation         (operation),
		.data_byte         (data_byte),
		.row               (row),
		.column            (column),
		.empty             (empty),
		.pop               (pop),
		.expander_byte     (expander_byte),
		.bus_write_address (bus_write_address),
		.end_of_transfer   (end_of_transfer),
		.last              (last),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void push_transfer(input logic [7:0] v, input logic is_data,
			input logic is_final);
		lcd_out_t e;
		logic [3:0] ctl_on;
		logic [3:0] ctl_off;
		ctl_on  = is_data ? CTL_DATA_EN_ON : CTL_CMD_EN_ON;
		ctl_off = is_data ? CTL_DATA_EN_OFF : CTL_CMD_EN_OFF;
		for (int i = 0; i < 4; i++) begin
			e.xbyte    = {(i < 2) ? v[7:4] : v[3:0], (i % 2 == 0) ? ctl_on : ctl_off};
			e.bus_addr = {dev_addr_model, 1'b0};
			e.eot      = (i == 3);
			e.fin      = is_final && (i == 3);
			expected_bytes.push_back(e);
		end
	endfunction

	function automatic void predict_lcd_bytes(input logic [1:0] op, input logic [7:0] d,
			input logic [1:0] r, input logic [4:0] c);
		case (op)
			OP_WRITE_CHAR: begin
				if (cursor_model == ADDR_ROW0_END) begin
					cursor_model = ADDR_ROW1_START;
					push_transfer(CMD_ROW1, 1'b0, 1'b0);
					row_wraps++;
				end
				if (cursor_model <= ADDR_ROW1_LAST) begin
					push_transfer(d, 1'b1, 1'b1);
					cursor_model = cursor_model + 7'd1;
				end else begin
					dropped_chars++;
				end
			end
			OP_RAW_CMD: push_transfer(d, 1'b0, 1'b1);
			OP_SET_CURSOR: begin
				if (r < ROW_LIMIT && c < COLUMN_LIMIT) begin
					cursor_model = {r[0], 2'b00, c[3:0]};
					push_transfer(CMD_SET_DDRAM | {1'b0, cursor_model}, 1'b0, 1'b1);
				end
			end
			default: ;
		endcase
	endfunction

	// predict on accepted requests, then check the popped byte
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				dev_addr_model = cfg_data;
				address_writes++;
			end
			if (push && !full) begin
				items_accepted++;
				base_size = expected_bytes.size();
				predict_lcd_bytes(operation, data_byte, row, column);
				if (row_check != FROM_MODEL) begin
					while (expected_bytes.size() > base_size)
						void'(expected_bytes.pop_back());
					if (row_check == LCD_BYTE)
						push_transfer(row_value, operation == OP_WRITE_CHAR, 1'b1);
				end
			end
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected expander byte %02h, nothing pending",
						$time, expander_byte);
					errors++;
				end else begin
					want = expected_bytes.pop_front();
					bytes_checked++;
					if (expander_byte !== want.xbyte) begin
						$display("%0t: expander_byte expected %02h, got %02h",
							$time, want.xbyte, expander_byte);
						errors++;
					end
					if (bus_write_address !== want.bus_addr) begin
						$display("%0t: bus_write_address expected %02h, got %02h",
							$time, want.bus_addr, bus_write_address);
						errors++;
					end
					if (end_of_transfer !== want.eot) begin
						$display("%0t: end_of_transfer expected %0b, got %0b",
							$time, want.eot, end_of_transfer);
						errors++;
					end
					if (last !== want.fin) begin
						$display("%0t: last expected %0b, got %0b", $time, want.fin, last);
						errors++;
					end
				end
			end
			if (pat_pos % 64 == 63)
				pop_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
			pop <= pop_pattern[pat_pos % 8];
			pat_pos++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)))
			idle_cycles = 0;
		else if (arst_n)
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [7:0] d, input logic [1:0] r,
			input logic [4:0] c, input row_check_e chk, input logic [7:0] v);
		push      <= 1'b1;
		operation <= op;
		data_byte <= d;
		row       <= r;
		column    <= c;
		row_check <= chk;
		row_value <= v;
		@(posedge clk);
		while (full) @(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 48 : int'($urandom_range(1, 10));
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_device_address(input logic [6:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int n_items);
		int sent;
		int run_len;
		logic [4:0] col;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 4) == 0) begin
				send_item(2'($urandom), 8'($urandom), 2'($urandom), 5'($urandom),
					FROM_MODEL, 8'h00);
				sent++;
			end else begin
				// aim near row ends to hit wraps and drops
				col = $urandom_range(0, 1) ? 5'($urandom_range(10, 15))
					: 5'($urandom_range(0, 15));
				send_item(OP_SET_CURSOR, 8'($urandom), 2'($urandom_range(0, 1)), col,
					FROM_MODEL, 8'h00);
				run_len = $urandom_range(1, 12);
				if (sent + run_len + 1 > n_items)
					run_len = n_items - sent - 1;
				repeat (run_len) begin
					if ($urandom_range(0, 7) == 0)
						send_item(OP_RAW_CMD, 8'($urandom), 2'($urandom), 5'($urandom),
							FROM_MODEL, 8'h00);
					else
						send_item(OP_WRITE_CHAR, 8'($urandom), 2'($urandom), 5'($urandom),
							FROM_MODEL, 8'h00);
				end
				sent += run_len + 1;
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		push           = 1'b0;
		pop            = 1'b0;
		operation      = OP_WRITE_CHAR;
		data_byte      = 8'h00;
		row            = 2'd0;
		column         = 5'd0;
		cfg_valid      = 1'b0;
		cfg_data       = 7'd0;
		row_check      = FROM_MODEL;
		row_value      = 8'h00;
		cursor_model   = 7'd0;
		dev_addr_model = DEVICE_ADDRESS_RESET;
		burst_left     = 1;
		directed_rows = '{
			'{OP_RAW_CMD,    8'h00, 2'd0, 5'd0,  LCD_BYTE,   8'h00},
			'{OP_RAW_CMD,    8'hFF, 2'd3, 5'd31, LCD_BYTE,   8'hFF},
			'{OP_WRITE_CHAR, 8'h00, 2'd0, 5'd0,  LCD_BYTE,   8'h00},
			'{OP_WRITE_CHAR, 8'hFF, 2'd0, 5'd0,  LCD_BYTE,   8'hFF},
			'{OP_SET_CURSOR, 8'h00, 2'd0, 5'd15, LCD_BYTE,   8'h8F},
			'{OP_WRITE_CHAR, 8'h41, 2'd0, 5'd0,  FROM_MODEL, 8'h00},
			'{OP_WRITE_CHAR, 8'h42, 2'd0, 5'd0,  FROM_MODEL, 8'h00},
			'{OP_SET_CURSOR, 8'hFF, 2'd1, 5'd15, LCD_BYTE,   8'hCF},
			'{OP_WRITE_CHAR, 8'h5A, 2'd0, 5'd0,  FROM_MODEL, 8'h00},
			'{OP_WRITE_CHAR, 8'h7E, 2'd0, 5'd0,  NO_OUTPUT,  8'h00},
			'{OP_RAW_CMD,    8'h01, 2'd0, 5'd0,  LCD_BYTE,   8'h01},
			'{OP_WRITE_CHAR, 8'h33, 2'd0, 5'd0,  NO_OUTPUT,  8'h00},
			'{OP_SET_CURSOR, 8'h00, 2'd2, 5'd0,  NO_OUTPUT,  8'h00},
			'{OP_SET_CURSOR, 8'h00, 2'd3, 5'd31, NO_OUTPUT,  8'h00},
			'{OP_SET_CURSOR, 8'h00, 2'd0, 5'd16, NO_OUTPUT,  8'h00},
			'{OP_SET_CURSOR, 8'h00, 2'd1, 5'd16, NO_OUTPUT,  8'h00},
			'{OP_UNUSED,     8'hA5, 2'd1, 5'd3,  NO_OUTPUT,  8'h00},
			'{OP_WRITE_CHAR, 8'h20, 2'd0, 5'd0,  NO_OUTPUT,  8'h00},
			'{OP_SET_CURSOR, 8'h00, 2'd1, 5'd0,  LCD_BYTE,   8'hC0},
			'{OP_WRITE_CHAR, 8'h55, 2'd0, 5'd0,  FROM_MODEL, 8'h00},
			'{OP_SET_CURSOR, 8'h00, 2'd0, 5'd0,  LCD_BYTE,   8'h80},
			'{OP_WRITE_CHAR, 8'h30, 2'd0, 5'd0,  FROM_MODEL, 8'h00}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].r,
				directed_rows[i].c, directed_rows[i].chk, directed_rows[i].value);
		wait_drained();
		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 0)
				write_device_address(7'h00);
			else if (phase == 1)
				write_device_address(7'h7F);
			else
				write_device_address(7'($urandom));
			run_random(37);
			wait_drained();
		end
		$display("Covered %0d requests (%0d row wraps, %0d dropped characters), %0d bytes checked",
			items_accepted, row_wraps, dropped_chars, bytes_checked);
		$display("across %0d device address settings, %0d mismatches",
			address_writes + 1, errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
